// ===== src/mplt_pkg.sv =====
package mplt_pkg;

    // Default structure of the growth history.
    localparam int RING_DEPTH_DEF     = 10;
    localparam int SUBSAMPLE_DEF      = 6;

    localparam int KB_W               = 32;
    localparam int GROWTH_W           = 33;

    // A stored sample is kept as its quotient and remainder by three, so that
    // the mean of three samples needs only adds and a tiny carry table.
    localparam int Q_W                = 31;
    localparam logic [KB_W-1:0] RECIP3 = 32'hAAAA_AAAB;

    typedef struct packed {
        logic [Q_W-1:0] quot;
        logic [1:0]     rem;
    } t_entry;

    // Remainder by three: radix-4 digits are each congruent to themselves
    // mod 3, so the digit sum is folded down until it is below three.
    function automatic logic [1:0] mod3(input logic [KB_W-1:0] v);
        logic [2:0] pair [8];
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        for (int i = 0; i < 8; i++) begin
            pair[i] = 3'(v[4*i +: 2]) + 3'(v[4*i+2 +: 2]);
        end
        s1 = '0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 6'(pair[i]);
        end
        s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
        s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
        return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    endfunction

endpackage

// ===== src/mplt_growth.sv =====
module mplt_growth #(
    parameter int RING_DEPTH = mplt_pkg::RING_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_store,
    input  mplt_pkg::t_entry                    i_entry,
    output logic signed [mplt_pkg::GROWTH_W-1:0] o_growth
);

    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int MEAN_W = mplt_pkg::Q_W + 2;

    // Shift line of subsampled RSS values, newest at tap zero.
    mplt_pkg::t_entry r_line [RING_DEPTH];
    logic [FILL_W-1:0]                    r_fill;
    logic signed [mplt_pkg::GROWTH_W-1:0] r_growth;

    logic [MEAN_W-1:0]                    new_mean;
    logic [MEAN_W-1:0]                    old_mean;
    logic signed [mplt_pkg::GROWTH_W-1:0] n_growth;
    logic                                 full_next;

    function automatic logic [MEAN_W-1:0] mean3(input mplt_pkg::t_entry a,
                                                input mplt_pkg::t_entry b,
                                                input mplt_pkg::t_entry c);
        logic [MEAN_W-1:0] qs;
        logic [2:0]        rs;
        logic [1:0]        carry;
        qs = MEAN_W'(a.quot) + MEAN_W'(b.quot) + MEAN_W'(c.quot);
        rs = 3'(a.rem) + 3'(b.rem) + 3'(c.rem);
        if (rs >= 3'd6) begin
            carry = 2'd2;
        end else if (rs >= 3'd3) begin
            carry = 2'd1;
        end else begin
            carry = 2'd0;
        end
        return qs + MEAN_W'(carry);
    endfunction

    // Means are taken over the line as it will stand after this store.
    always_comb begin
        new_mean  = mean3(i_entry, r_line[0], r_line[1]);
        old_mean  = mean3(r_line[RING_DEPTH-2], r_line[RING_DEPTH-3],
                          r_line[RING_DEPTH-4]);
        n_growth  = $signed(mplt_pkg::GROWTH_W'(new_mean))
                  - $signed(mplt_pkg::GROWTH_W'(old_mean));
        full_next = (r_fill >= FILL_W'(RING_DEPTH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_store) begin
            r_line[0] <= i_entry;
            for (int i = 1; i < RING_DEPTH; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_growth <= '0;
        end else if (i_store) begin
            if (r_fill < FILL_W'(RING_DEPTH)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            r_growth <= full_next ? n_growth : '0;
        end
    end

    assign o_growth = r_growth;

endmodule

// ===== src/memory_pressure_level_tracker.sv =====
// Memory pressure level tracker.
//
// Each transfer on the slave stream is one monitor tick carrying the resident,
// virtual and available memory sizes in kB. Each tick produces exactly one
// transfer on the master stream with the pressure level after that tick, an
// alert flag, the alert cause and the smoothed RSS growth.
//
// The block is a three-register pipeline (input, conditioned flags, result)
// and takes one transfer per cycle unless the receiver stalls. Threshold
// compares settle in the first stage; level, alert and the ring update per
// tick all settle in the last stage, so ticks may follow back to back.
//
// When the receiver stalls, the result register holds and the pipeline fills;
// slave tready drops only once all three registers are occupied, and nothing
// is lost. Thresholds are written through the configuration channel, which is
// always ready; writes should only be made while no tick is in flight.
//
// Reset returns all thresholds to their defaults, the level to none, the
// alert gap counters to ready and empties the growth history. No clearing
// pass is needed: growth reads as zero until the history is full.
module memory_pressure_level_tracker #(
    parameter int RING_DEPTH      = mplt_pkg::RING_DEPTH_DEF,
    parameter int SUBSAMPLE_RATIO = mplt_pkg::SUBSAMPLE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] rss_kb, [63:32] vsize_kb, [95:64] avail_kb
    input  logic [95:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] level, [2] alert, [5:3] cause, [38:6] growth, [39] zero
    output logic [39:0] m_axis_tdata
);

    localparam int KB_W     = mplt_pkg::KB_W;
    localparam int SCALE_W  = KB_W + 4;
    localparam int GAP_W    = 16;
    localparam int CNT_W    = (SUBSAMPLE_RATIO > 1) ? $clog2(SUBSAMPLE_RATIO) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUBSAMPLE_RATIO - 1);

    localparam logic [1:0] LVL_NONE     = 2'd0;
    localparam logic [1:0] LVL_ELEVATED = 2'd1;
    localparam logic [1:0] LVL_WARNING  = 2'd2;
    localparam logic [1:0] LVL_CRITICAL = 2'd3;

    localparam logic [2:0] CAUSE_RSS_CRIT   = 3'd0;
    localparam logic [2:0] CAUSE_RSS_WARN   = 3'd1;
    localparam logic [2:0] CAUSE_AVAIL_CRIT = 3'd2;
    localparam logic [2:0] CAUSE_AVAIL_WARN = 3'd3;
    localparam logic [2:0] CAUSE_GROWTH     = 3'd4;
    localparam logic [2:0] CAUSE_HELD       = 3'd5;

    localparam logic [2:0] REG_WARN_RSS       = 3'd0;
    localparam logic [2:0] REG_CRITICAL_RSS   = 3'd1;
    localparam logic [2:0] REG_WARN_AVAIL     = 3'd2;
    localparam logic [2:0] REG_CRITICAL_AVAIL = 3'd3;
    localparam logic [2:0] REG_GROWTH_LIMIT   = 3'd4;
    localparam logic [2:0] REG_ALERT_GAP      = 3'd5;

    localparam logic [GAP_W-1:0] TICKS_MAX = '1;

    // Threshold comparisons do not depend on the level, so they are resolved
    // one stage ahead of the level logic.
    typedef struct packed {
        logic no_data;
        logic rss_crit;
        logic rss_warn;
        logic rss_crit_hold;
        logic rss_warn_hold;
        logic rss_near;
        logic av_crit;
        logic av_warn;
        logic av_crit_hold;
        logic av_warn_hold;
        logic av_low;
    } t_flags;

    // Configuration registers.
    logic [KB_W-1:0]  r_warn_rss;
    logic [KB_W-1:0]  r_crit_rss;
    logic [KB_W-1:0]  r_warn_av;
    logic [KB_W-1:0]  r_crit_av;
    logic [KB_W-1:0]  r_growth_limit;
    logic [GAP_W-1:0] r_alert_gap;

    // Pipeline registers.
    logic             r_in_valid;
    logic [KB_W-1:0]  r_in_rss;
    logic [KB_W-1:0]  r_in_vsz;
    logic [KB_W-1:0]  r_in_avail;

    logic             r_mid_valid;
    t_flags           r_mid_flags;
    mplt_pkg::t_entry r_mid_entry;

    logic             r_out_valid;
    logic [1:0]       r_out_level;
    logic             r_out_alert;
    logic [2:0]       r_out_cause;
    logic signed [mplt_pkg::GROWTH_W-1:0] r_out_growth;

    // Tracker state.
    logic [1:0]       r_level;
    logic [CNT_W-1:0] r_sub;
    logic [GAP_W-1:0] r_ticks [3];

    logic             en_out;
    logic             en_mid;
    logic             en_in;
    logic             tick_done;
    logic             store;

    t_flags           n_flags;
    mplt_pkg::t_entry n_entry;
    logic [2*KB_W-1:0] prod3;
    logic [SCALE_W-1:0] rss_x10p9;
    logic [SCALE_W-1:0] av_x10;
    logic [SCALE_W-1:0] crit_rss_x9;
    logic [SCALE_W-1:0] warn_rss_x9;
    logic [SCALE_W-1:0] crit_av_x11;
    logic [SCALE_W-1:0] warn_av_x11;
    logic               av_known;

    logic signed [mplt_pkg::GROWTH_W-1:0] growth;
    logic [1:0]       rss_lvl;
    logic [1:0]       av_lvl;
    logic [1:0]       lvl;
    logic [1:0]       n_level;
    logic [1:0]       sel;
    logic             grow_hi;
    logic             fire;
    logic [2:0]       n_cause;
    logic [GAP_W-1:0] ticks_inc [3];
    logic [GAP_W-1:0] n_ticks   [3];

    // A slot frees when its content moves on, so a full pipeline still takes
    // a new transfer in the same cycle that the receiver takes a result.
    assign en_out    = !r_out_valid || m_axis_tready;
    assign en_mid    = !r_mid_valid || en_out;
    assign en_in     = !r_in_valid || en_mid;
    assign tick_done = r_mid_valid && en_out;
    assign store     = tick_done && (r_sub == CNT_LAST);

    assign s_axis_tready = en_in;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_rss     <= KB_W'(30720);
            r_crit_rss     <= KB_W'(40960);
            r_warn_av      <= KB_W'(15360);
            r_crit_av      <= KB_W'(8192);
            r_growth_limit <= KB_W'(1024);
            r_alert_gap    <= GAP_W'(60);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WARN_RSS:       r_warn_rss     <= i_cfg_data;
                REG_CRITICAL_RSS:   r_crit_rss     <= i_cfg_data;
                REG_WARN_AVAIL:     r_warn_av      <= i_cfg_data;
                REG_CRITICAL_AVAIL: r_crit_av      <= i_cfg_data;
                REG_GROWTH_LIMIT:   r_growth_limit <= i_cfg_data;
                REG_ALERT_GAP:      r_alert_gap    <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // First stage: threshold compares and the divide-by-three of RSS. The
    // hysteresis tests avoid dividing by 100: for integer x,
    // x >= floor(0.9 t) is 10x + 9 >= 9t, and x <= floor(1.1 t) is 10x <= 11t.
    always_comb begin
        prod3      = {{KB_W{1'b0}}, r_in_rss} * {{KB_W{1'b0}}, mplt_pkg::RECIP3};
        n_entry.quot = prod3[2*KB_W-1 -: mplt_pkg::Q_W];
        n_entry.rem  = mplt_pkg::mod3(r_in_rss);

        rss_x10p9   = (SCALE_W'(r_in_rss) << 3) + (SCALE_W'(r_in_rss) << 1)
                    + SCALE_W'(9);
        av_x10      = (SCALE_W'(r_in_avail) << 3) + (SCALE_W'(r_in_avail) << 1);
        crit_rss_x9 = (SCALE_W'(r_crit_rss) << 3) + SCALE_W'(r_crit_rss);
        warn_rss_x9 = (SCALE_W'(r_warn_rss) << 3) + SCALE_W'(r_warn_rss);
        crit_av_x11 = (SCALE_W'(r_crit_av) << 3) + (SCALE_W'(r_crit_av) << 1)
                    + SCALE_W'(r_crit_av);
        warn_av_x11 = (SCALE_W'(r_warn_av) << 3) + (SCALE_W'(r_warn_av) << 1)
                    + SCALE_W'(r_warn_av);
        av_known    = (r_in_avail != '0);

        n_flags.no_data       = (r_in_rss == '0) && (r_in_vsz == '0);
        n_flags.rss_crit      = (r_in_rss >= r_crit_rss);
        n_flags.rss_warn      = (r_in_rss >= r_warn_rss);
        n_flags.rss_crit_hold = (rss_x10p9 >= crit_rss_x9);
        n_flags.rss_warn_hold = (rss_x10p9 >= warn_rss_x9);
        n_flags.rss_near      = (r_in_rss >= (r_warn_rss >> 1));
        n_flags.av_crit       = av_known && (r_in_avail <= r_crit_av);
        n_flags.av_warn       = av_known && (r_in_avail <= r_warn_av);
        n_flags.av_crit_hold  = av_known && (av_x10 <= crit_av_x11);
        n_flags.av_warn_hold  = av_known && (av_x10 <= warn_av_x11);
        n_flags.av_low        = av_known
                              && ((KB_W + 1)'(r_in_avail) <= {r_warn_av, 1'b0});
    end

    // Second stage: level with hysteresis, rate-limited alert and cause.
    always_comb begin
        if (r_mid_flags.rss_crit) begin
            rss_lvl = LVL_CRITICAL;
        end else if (r_level == LVL_CRITICAL && r_mid_flags.rss_crit_hold) begin
            rss_lvl = LVL_CRITICAL;
        end else if (r_mid_flags.rss_warn) begin
            rss_lvl = LVL_WARNING;
        end else if (r_level >= LVL_WARNING && r_mid_flags.rss_warn_hold) begin
            rss_lvl = LVL_WARNING;
        end else begin
            rss_lvl = LVL_NONE;
        end

        if (r_mid_flags.av_crit) begin
            av_lvl = LVL_CRITICAL;
        end else if (r_level == LVL_CRITICAL && r_mid_flags.av_crit_hold) begin
            av_lvl = LVL_CRITICAL;
        end else if (r_mid_flags.av_warn) begin
            av_lvl = LVL_WARNING;
        end else if (r_level >= LVL_WARNING && r_mid_flags.av_warn_hold) begin
            av_lvl = LVL_WARNING;
        end else begin
            av_lvl = LVL_NONE;
        end

        lvl     = (av_lvl > rss_lvl) ? av_lvl : rss_lvl;
        grow_hi = (growth > $signed(mplt_pkg::GROWTH_W'(r_growth_limit)));
        if ((r_mid_flags.rss_near || r_mid_flags.av_low) && grow_hi
                && lvl == LVL_NONE) begin
            lvl = LVL_ELEVATED;
        end

        // Every gap counter ages by one tick before the alert test.
        for (int k = 0; k < 3; k++) begin
            ticks_inc[k] = (r_ticks[k] == TICKS_MAX) ? r_ticks[k]
                                                     : r_ticks[k] + GAP_W'(1);
        end

        sel  = lvl - 2'd1;
        fire = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (!r_mid_flags.no_data && lvl != LVL_NONE && sel == 2'(k)
                    && ticks_inc[k] >= r_alert_gap) begin
                fire = 1'b1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_ticks[k] = (fire && sel == 2'(k)) ? '0 : ticks_inc[k];
        end

        // A tick with no data keeps the previous level and never alerts.
        n_level = r_mid_flags.no_data ? r_level : lvl;

        if (!fire) begin
            n_cause = CAUSE_RSS_CRIT;
        end else if (r_mid_flags.rss_crit) begin
            n_cause = CAUSE_RSS_CRIT;
        end else if (r_mid_flags.rss_warn) begin
            n_cause = CAUSE_RSS_WARN;
        end else if (r_mid_flags.av_crit) begin
            n_cause = CAUSE_AVAIL_CRIT;
        end else if (r_mid_flags.av_warn) begin
            n_cause = CAUSE_AVAIL_WARN;
        end else if (grow_hi) begin
            n_cause = CAUSE_GROWTH;
        end else begin
            n_cause = CAUSE_HELD;
        end
    end

    // Growth reflects the history before this tick's sample is stored.
    mplt_growth #(
        .RING_DEPTH (RING_DEPTH)
    ) u_growth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_store  (store),
        .i_entry  (r_mid_entry),
        .o_growth (growth)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= LVL_NONE;
            r_sub       <= '0;
            for (int k = 0; k < 3; k++) begin
                r_ticks[k] <= TICKS_MAX;
            end
        end else begin
            if (en_in) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (en_mid) begin
                r_mid_valid <= r_in_valid;
            end
            if (en_out) begin
                r_out_valid <= r_mid_valid;
            end
            if (tick_done) begin
                r_level <= n_level;
                r_sub   <= (r_sub == CNT_LAST) ? '0 : r_sub + CNT_W'(1);
                for (int k = 0; k < 3; k++) begin
                    r_ticks[k] <= n_ticks[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in_rss   <= s_axis_tdata[31:0];
            r_in_vsz   <= s_axis_tdata[63:32];
            r_in_avail <= s_axis_tdata[95:64];
        end
        if (en_mid) begin
            r_mid_flags <= n_flags;
            r_mid_entry <= n_entry;
        end
        if (tick_done) begin
            r_out_level  <= n_level;
            r_out_alert  <= fire;
            r_out_cause  <= n_cause;
            r_out_growth <= growth;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_growth, r_out_cause, r_out_alert, r_out_level};

endmodule
